// File: design/bstk_pkg.sv
`timescale 1ns / 1ps

package bstk_pkg;

    // Field widths fixed by the item formats.
    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int IDX_W         = 6;
    localparam int STATUS_W      = 2;
    // Widest entry count that the deepest supported stack needs.
    localparam int CNT_MAX_W     = 7;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_CHANGE  = 3'd3,
        OP_DISPLAY = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // A classified command as it travels from the front to the back.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

endpackage

// File: design/bstk_in_if.sv
`timescale 1ns / 1ps

interface bstk_in_if import bstk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;

    modport source (output valid, output opcode, output value, output index, input ready);
    modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

// File: design/bstk_out_if.sv
`timescale 1ns / 1ps

interface bstk_out_if import bstk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

// File: design/bstk_ram.sv
`timescale 1ns / 1ps

module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bstk_front.sv
`timescale 1ns / 1ps

module bstk_front import bstk_pkg::*; (
    bstk_in_if.sink cmd,
    output logic    q_wr_valid,
    input  logic    q_wr_ready,
    output cmd_t    q_wr_cmd
);

    logic op_known;

    // Undefined opcodes are taken and dropped; they cause no result.
    always_comb
    begin
        op_known = 1'b0;
        unique case (cmd.opcode)
            OP_PUSH, OP_POP, OP_PEEK, OP_CHANGE, OP_DISPLAY: op_known = 1'b1;
            default:                                         op_known = 1'b0;
        endcase
    end

    assign cmd.ready      = q_wr_ready;
    assign q_wr_valid     = cmd.valid && op_known;
    assign q_wr_cmd.op    = op_t'(cmd.opcode);
    assign q_wr_cmd.value = cmd.value;
    assign q_wr_cmd.index = cmd.index;

endmodule

// File: design/bstk_queue.sv
`timescale 1ns / 1ps

module bstk_queue import bstk_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    // Two entries let the front take an item while the back is busy.
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        priority if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: design/bstk_back.sv
`timescale 1ns / 1ps

module bstk_back import bstk_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    bstk_out_if.source  rsp
);

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic              use_ram_reg, use_ram_next;
    logic              display_reg, display_next;
    status_t           status_reg, status_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              is_full, is_empty, idx_ok, walk_more;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign idx_ok    = (CNT_MAX_W'(q_cmd.index) < CNT_MAX_W'(count_reg));
    assign walk_more = display_reg && (pos_reg != '0);

    bstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free && !walk_more)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready         = 1'b0;
        count_next      = count_reg;
        pos_next        = pos_reg;
        use_ram_next    = use_ram_reg;
        display_next    = display_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = AW'(count_reg);
        wr_data         = q_cmd.value;
        rd_en           = 1'b0;
        rd_addr         = AW'(count_reg - CW'(1));
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                q_ready      = 1'b1;
                use_ram_next = 1'b0;
                display_next = 1'b0;
                status_next  = ST_OK;
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                use_ram_next = 1'b1;
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        OP_PEEK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                use_ram_next = 1'b1;
                            end
                        end
                        OP_CHANGE:
                        begin
                            if (idx_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = q_cmd.index[AW-1:0];
                            end
                            else
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                use_ram_next = 1'b1;
                                display_next = 1'b1;
                                pos_next     = AW'(count_reg - CW'(1));
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = use_ram_reg ? rd_data : '0;
                    out_status_next = status_reg;
                    out_last_next   = !walk_more;
                    if (walk_more)
                    begin
                        // The next entry down is read as this one leaves.
                        pos_next = pos_reg - AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg - AW'(1);
                    end
                end
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            display_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            display_reg   <= display_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        use_ram_reg    <= use_ram_next;
        status_reg     <= status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

endmodule

// File: design/bounded_stack_with_indexed_edit.sv
`timescale 1ns / 1ps

// Channel   Direction  Fields                  Item
// cmd       in         opcode, value, index    one stack command
// rsp       out        data, status, last      one result; last ends a command's run
//
// A push, pop, peek or change passes through both back-end states: in the idle
// state it accesses the stack memory, in the emit state it loads the result
// register. A display reads one entry at a time through the single read port.
// Reset clears the entry count, the command queue and the result valid flag;
// the stack memory itself is not cleared. A stalled result holds the back end,
// while the two-entry queue lets the front keep taking items until it fills.

module bounded_stack_with_indexed_edit import bstk_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bstk_in_if.sink    cmd,
    bstk_out_if.source rsp
);

    // Front to queue: commands with a defined opcode only.
    logic q_wr_valid;
    logic q_wr_ready;
    cmd_t q_wr_cmd;

    // Queue to back end.
    logic q_rd_valid;
    logic q_rd_ready;
    cmd_t q_rd_cmd;

    // The front decodes the opcode and drops undefined ones, so that every
    // command the back end sees causes at least one result.
    bstk_front u_front (
        .cmd        (cmd),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_cmd   (q_wr_cmd)
    );

    // The queue decouples acceptance from execution, so a stall on the
    // result side does not at once stop the input side.
    bstk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_cmd   (q_wr_cmd),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_cmd   (q_rd_cmd)
    );

    // The back end owns the entry count and the stack memory, carries out
    // one command at a time and walks the stack from top to bottom for a
    // display.
    bstk_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_rd_valid),
        .q_ready (q_rd_ready),
        .q_cmd   (q_rd_cmd),
        .rsp     (rsp)
    );

endmodule
